[rtl/core/rv32se_pkg.sv]
// ----------------------------------------------------------------------------
// RV32 subset executor package
// Shared types, instruction encodings and status codes for the executor.
// ----------------------------------------------------------------------------
package rv32se_pkg;

  typedef logic [31:0] word_t;
  typedef logic [1:0]  status_t;
  typedef logic [4:0]  reg_idx_t;

  // Result status codes.
  localparam status_t STAT_NORMAL  = 2'd0;
  localparam status_t STAT_HALT    = 2'd1;
  localparam status_t STAT_INVALID = 2'd2;
  localparam status_t STAT_HALTED  = 2'd3;

  // Major opcodes and function codes of the supported instructions.
  localparam logic [6:0] OP_AUIPC = 7'h17;
  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_IMM   = 7'h13;
  localparam logic [6:0] OP_JAL   = 7'h6f;

  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SW   = 3'd2;
  localparam logic [2:0] F3_ADDI = 3'd0;

  localparam word_t    EBREAK_WORD = 32'h0010_0073;
  localparam reg_idx_t REG_A0      = 5'd10;

  typedef struct packed {
    word_t    next_pc;
    status_t  status;
    logic     reg_write;
    reg_idx_t reg_index;
    word_t    reg_value;
    word_t    exit_code;
  } out_word_t;

endpackage

[rtl/core/rv32se_if.sv]
// ----------------------------------------------------------------------------
// RV32 subset executor channels
// Valid/ready channels for instruction words in and result words out.
// ----------------------------------------------------------------------------
interface rv32se_in_if;
  logic               valid;
  logic               ready;
  rv32se_pkg::word_t  pc_value;
  rv32se_pkg::word_t  instruction_word;

  modport source (output valid, output pc_value, output instruction_word, input ready);
  modport sink   (input valid, input pc_value, input instruction_word, output ready);
endinterface

interface rv32se_out_if;
  logic                 valid;
  logic                 ready;
  rv32se_pkg::word_t    next_pc;
  rv32se_pkg::status_t  status;
  logic                 reg_write;
  rv32se_pkg::reg_idx_t reg_index;
  rv32se_pkg::word_t    reg_value;
  rv32se_pkg::word_t    exit_code;

  modport source (output valid, output next_pc, output status, output reg_write,
                  output reg_index, output reg_value, output exit_code, input ready);
  modport sink   (input valid, input next_pc, input status, input reg_write,
                  input reg_index, input reg_value, input exit_code, output ready);
endinterface

[rtl/core/rv32_subset_instruction_executor_top.sv]
// ----------------------------------------------------------------------------
// RV32 subset instruction executor
// Executes auipc, lbu, sb, addi, jal, sw and ebreak against a register file
// and a byte data memory, one result word per instruction word.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries a program counter and an already fetched instruction word;
//   out_chan returns the next pc, status, register write and exit code.
//   An accepted word passes an operand stage (register file read data,
//   forwarding, address and result arithmetic, store write, load read issue)
//   and a memory stage (load byte select, register write-back), then enters a
//   four-entry result queue, from which its result is offered.
//   Throughput is one word per cycle: both memories take one access per
//   cycle per port, and words are accepted while in-flight words plus queued
//   results number fewer than four.
//   When the receiver stalls, results collect in the queue and in_chan.ready
//   drops once queued results plus words in the operand and memory stages number four.
//   After reset the data memory is cleared one row of four bytes per cycle,
//   all 2^(DMEM_ADDR_BITS-2) rows (1024 by default); no word is accepted
//   meanwhile. Registers read as zero until first written. An ebreak or an
//   invalid word halts the block until the next reset.
// ----------------------------------------------------------------------------
module rv32_subset_instruction_executor_top #(
  parameter int DMEM_ADDR_BITS = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  rv32se_in_if.sink      in_chan,
  rv32se_out_if.source   out_chan
);

  localparam int RowBits   = DMEM_ADDR_BITS - 2;
  localparam int Rows      = 1 << RowBits;
  localparam int Lanes     = 4;
  localparam int FifoDepth = 4;

  // --------------------------------------------------------------------------
  // Data memory clearing pass
  // --------------------------------------------------------------------------
  logic               clearing_r;
  logic [RowBits-1:0] clr_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clearing_r) begin
      clr_row_r <= clr_row_r + RowBits'(1);
      if (clr_row_r == RowBits'(Rows - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input acceptance
  // --------------------------------------------------------------------------
  logic       e_v_r;
  logic       m_v_r;
  logic [2:0] fifo_cnt_r;
  logic [2:0] occupancy;
  logic       in_acc;

  assign occupancy      = fifo_cnt_r + 3'(e_v_r) + 3'(m_v_r);
  assign in_chan.ready  = !clearing_r && (occupancy < 3'(FifoDepth));
  assign in_acc         = in_chan.valid && in_chan.ready;

  // --------------------------------------------------------------------------
  // Register file: two synchronous read ports, one write port
  // --------------------------------------------------------------------------
  rv32se_pkg::word_t    rf_mem [32];
  logic [31:0]          rf_vld_r;
  rv32se_pkg::word_t    rf_rd1_r;
  rv32se_pkg::word_t    rf_rd2_r;
  logic                 rd1_vld_r;
  logic                 rd2_vld_r;
  rv32se_pkg::reg_idx_t rs1_sel;
  rv32se_pkg::reg_idx_t rs2_sel;
  logic                 wb_en;
  rv32se_pkg::reg_idx_t wb_idx;
  rv32se_pkg::word_t    wb_val;

  // An ebreak reads a0 through the first port so that it can report it.
  assign rs1_sel = (in_chan.instruction_word == rv32se_pkg::EBREAK_WORD) ?
                   rv32se_pkg::REG_A0 : in_chan.instruction_word[19:15];
  assign rs2_sel = in_chan.instruction_word[24:20];

  always_ff @(posedge clk) begin
    if (wb_en) begin
      rf_mem[wb_idx] <= wb_val;
    end
    rf_rd1_r  <= rf_mem[rs1_sel];
    rf_rd2_r  <= rf_mem[rs2_sel];
    rd1_vld_r <= rf_vld_r[rs1_sel];
    rd2_vld_r <= rf_vld_r[rs2_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (wb_en) begin
      rf_vld_r[wb_idx] <= 1'b1;
    end
  end

  // The write made at the edge that read the operands is not in the read data.
  logic                 lw_v_r;
  rv32se_pkg::reg_idx_t lw_idx_r;
  rv32se_pkg::word_t    lw_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else begin
      lw_v_r <= wb_en;
    end
    lw_idx_r <= wb_idx;
    lw_val_r <= wb_val;
  end

  // --------------------------------------------------------------------------
  // Operand stage
  // --------------------------------------------------------------------------
  rv32se_pkg::word_t    e_pc_r;
  rv32se_pkg::word_t    e_word_r;
  rv32se_pkg::reg_idx_t e_rs1_r;
  rv32se_pkg::reg_idx_t e_rs2_r;
  logic                 halted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= in_acc;
    end
    if (in_acc) begin
      e_pc_r   <= in_chan.pc_value;
      e_word_r <= in_chan.instruction_word;
      e_rs1_r  <= rs1_sel;
      e_rs2_r  <= rs2_sel;
    end
  end

  rv32se_pkg::word_t    src1;
  rv32se_pkg::word_t    src2;
  rv32se_pkg::word_t    m_res;
  logic                 m_wr_r;
  rv32se_pkg::reg_idx_t m_rd_r;

  always_comb begin
    if (wb_en && (m_rd_r == e_rs1_r)) begin
      src1 = m_res;
    end else if (lw_v_r && (lw_idx_r == e_rs1_r)) begin
      src1 = lw_val_r;
    end else begin
      src1 = rd1_vld_r ? rf_rd1_r : '0;
    end
    if (wb_en && (m_rd_r == e_rs2_r)) begin
      src2 = m_res;
    end else if (lw_v_r && (lw_idx_r == e_rs2_r)) begin
      src2 = lw_val_r;
    end else begin
      src2 = rd2_vld_r ? rf_rd2_r : '0;
    end
  end

  logic [6:0]           opcode;
  logic [2:0]           funct3;
  rv32se_pkg::reg_idx_t e_rd;
  logic is_auipc, is_lbu, is_sb, is_addi, is_jal, is_sw, is_ebreak, is_known;
  rv32se_pkg::word_t    imm_i, imm_s, imm_j, imm_mem;
  logic                 e_live;

  assign opcode    = e_word_r[6:0];
  assign funct3    = e_word_r[14:12];
  assign e_rd      = e_word_r[11:7];
  assign is_auipc  = (opcode == rv32se_pkg::OP_AUIPC);
  assign is_lbu    = (opcode == rv32se_pkg::OP_LOAD)  && (funct3 == rv32se_pkg::F3_LBU);
  assign is_sb     = (opcode == rv32se_pkg::OP_STORE) && (funct3 == rv32se_pkg::F3_SB);
  assign is_addi   = (opcode == rv32se_pkg::OP_IMM)   && (funct3 == rv32se_pkg::F3_ADDI);
  assign is_jal    = (opcode == rv32se_pkg::OP_JAL);
  assign is_sw     = (opcode == rv32se_pkg::OP_STORE) && (funct3 == rv32se_pkg::F3_SW);
  assign is_ebreak = (e_word_r == rv32se_pkg::EBREAK_WORD);
  assign is_known  = is_auipc || is_lbu || is_sb || is_addi || is_jal || is_sw || is_ebreak;

  assign imm_i   = {{20{e_word_r[31]}}, e_word_r[31:20]};
  assign imm_s   = {{20{e_word_r[31]}}, e_word_r[31:25], e_word_r[11:7]};
  assign imm_j   = {{11{e_word_r[31]}}, e_word_r[31], e_word_r[19:12], e_word_r[20],
                    e_word_r[30:21], 1'b0};
  assign imm_mem = is_lbu ? imm_i : imm_s;

  assign e_live  = e_v_r && !halted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
    end else if (e_live && (is_ebreak || !is_known)) begin
      halted_r <= 1'b1;
    end
  end

  rv32se_pkg::word_t    e_value;
  rv32se_pkg::word_t    e_next_pc;
  rv32se_pkg::status_t  e_status;
  logic                 e_wr;

  always_comb begin
    priority if (is_auipc) begin
      e_value = e_pc_r + {e_word_r[31:12], 12'b0};
    end else if (is_addi) begin
      e_value = src1 + imm_i;
    end else if (is_jal) begin
      e_value = e_pc_r + 32'd4;
    end else begin
      e_value = '0;
    end

    if (halted_r) begin
      e_next_pc = e_pc_r;
    end else if (is_jal) begin
      e_next_pc = e_pc_r + imm_j;
    end else begin
      e_next_pc = e_pc_r + 32'd4;
    end

    priority if (halted_r) begin
      e_status = rv32se_pkg::STAT_HALTED;
    end else if (is_ebreak) begin
      e_status = rv32se_pkg::STAT_HALT;
    end else if (!is_known) begin
      e_status = rv32se_pkg::STAT_INVALID;
    end else begin
      e_status = rv32se_pkg::STAT_NORMAL;
    end
  end

  assign e_wr = e_live && (is_auipc || is_lbu || is_addi || is_jal) && (e_rd != '0);

  // --------------------------------------------------------------------------
  // Data memory: four byte lanes, lane = address bits [1:0]
  // --------------------------------------------------------------------------
  logic [DMEM_ADDR_BITS-1:0] d_addr;
  logic [RowBits-1:0]        d_row;
  logic [1:0]                d_lo;
  logic                      st_en;
  logic [RowBits-1:0]        lane_row [Lanes];
  logic [7:0]                lane_wd  [Lanes];
  logic                      lane_we  [Lanes];
  logic [7:0]                lane_rd_r [Lanes];

  assign d_addr = src1[DMEM_ADDR_BITS-1:0] + imm_mem[DMEM_ADDR_BITS-1:0];
  assign d_row  = d_addr[DMEM_ADDR_BITS-1:2];
  assign d_lo   = d_addr[1:0];
  assign st_en  = e_live && (is_sb || is_sw);

  // A word store that crosses a row boundary puts its upper bytes in the
  // lower lanes of the next row, wrapping at the top of the memory.
  always_comb begin
    logic [1:0] bsel;
    bsel = '0;
    for (int l = 0; l < Lanes; l++) begin
      bsel = 2'(l) - d_lo;
      if (clearing_r) begin
        lane_row[l] = clr_row_r;
        lane_wd[l]  = '0;
        lane_we[l]  = 1'b1;
      end else begin
        lane_row[l] = (2'(l) < d_lo) ? d_row + RowBits'(1) : d_row;
        lane_wd[l]  = src2[{bsel, 3'b000} +: 8];
        lane_we[l]  = st_en && (is_sw || (2'(l) == d_lo));
      end
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    logic [7:0] mem [Rows];

    always_ff @(posedge clk) begin
      if (lane_we[g]) begin
        mem[lane_row[g]] <= lane_wd[g];
      end
      lane_rd_r[g] <= mem[lane_row[g]];
    end
  end

  // --------------------------------------------------------------------------
  // Memory stage and write-back
  // --------------------------------------------------------------------------
  rv32se_pkg::word_t    m_next_pc_r;
  rv32se_pkg::status_t  m_status_r;
  rv32se_pkg::word_t    m_value_r;
  rv32se_pkg::word_t    m_exit_r;
  logic                 m_load_r;
  logic [1:0]           m_lane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= e_v_r;
    end
    if (e_v_r) begin
      m_next_pc_r <= e_next_pc;
      m_status_r  <= e_status;
      m_wr_r      <= e_wr;
      m_rd_r      <= e_wr ? e_rd : '0;
      m_value_r   <= e_value;
      m_exit_r    <= (e_live && is_ebreak) ? src1 : '0;
      m_load_r    <= is_lbu;
      m_lane_r    <= d_lo;
    end
  end

  assign m_res  = m_load_r ? {24'b0, lane_rd_r[m_lane_r]} : m_value_r;
  assign wb_en  = m_v_r && m_wr_r;
  assign wb_idx = m_rd_r;
  assign wb_val = m_res;

  rv32se_pkg::out_word_t m_out;

  assign m_out.next_pc   = m_next_pc_r;
  assign m_out.status    = m_status_r;
  assign m_out.reg_write = m_wr_r;
  assign m_out.reg_index = m_rd_r;
  assign m_out.reg_value = m_wr_r ? m_res : '0;
  assign m_out.exit_code = m_exit_r;

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  rv32se_pkg::out_word_t fifo_mem [FifoDepth];
  logic [1:0]            wr_ptr_r;
  logic [1:0]            rd_ptr_r;
  logic                  push;
  logic                  pop;
  rv32se_pkg::out_word_t head;

  assign push = m_v_r;
  assign pop  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= m_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      fifo_cnt_r <= fifo_cnt_r + 3'(push) - 3'(pop);
    end
  end

  assign head               = fifo_mem[rd_ptr_r];
  assign out_chan.valid     = (fifo_cnt_r != '0);
  assign out_chan.next_pc   = head.next_pc;
  assign out_chan.status    = head.status;
  assign out_chan.reg_write = head.reg_write;
  assign out_chan.reg_index = head.reg_index;
  assign out_chan.reg_value = head.reg_value;
  assign out_chan.exit_code = head.exit_code;

endmodule

[rtl/core/rv32se_checker.sv]
// ----------------------------------------------------------------------------
// RV32 subset executor checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rv32se_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input rv32se_pkg::word_t    out_next_pc,
  input rv32se_pkg::status_t  out_status,
  input logic                 out_reg_write,
  input rv32se_pkg::reg_idx_t out_reg_index,
  input rv32se_pkg::word_t    out_reg_value,
  input rv32se_pkg::word_t    out_exit_code
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc) && $stable(out_status)
      && $stable(out_reg_write) && $stable(out_reg_index) && $stable(out_reg_value)
      && $stable(out_exit_code))
    else $error("result word changed while stalled");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // Only a normal instruction writes a register, and never x0.
  a_write_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_write |->
      out_status == rv32se_pkg::STAT_NORMAL && out_reg_index != '0)
    else $error("register write with abnormal status or to x0");

  // Without a write the register fields read as zero.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_write |-> out_reg_index == '0 && out_reg_value == '0)
    else $error("register fields set without a write");

  // The exit code is only reported at a halt.
  a_exit_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rv32se_pkg::STAT_HALT |-> out_exit_code == '0)
    else $error("exit code set outside a halt");

endmodule

bind rv32_subset_instruction_executor_top rv32se_checker u_rv32se_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_next_pc   (out_chan.next_pc),
  .out_status    (out_chan.status),
  .out_reg_write (out_chan.reg_write),
  .out_reg_index (out_chan.reg_index),
  .out_reg_value (out_chan.reg_value),
  .out_exit_code (out_chan.exit_code)
);
